// ===== hdl/jse_pkg.sv =====
// shared types and constants of the json string escaper
package jse_pkg;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // kind of body that the back end emits after the optional opening quote
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLAIN = 2'd0;  // the byte itself
  localparam kind_t KIND_ESC   = 2'd1;  // backslash then ch
  localparam kind_t KIND_UNI   = 2'd2;  // backslash u 0 0 then two hex digits of ch
  localparam kind_t KIND_CLOSE = 2'd3;  // closing quote

  // ascii codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // longest output run of one item: opening quote plus a unicode escape
  localparam int unsigned MAX_RUN = 7;
  typedef logic [$clog2(MAX_RUN)-1:0] step_t;

  // work descriptor passed from front to back
  typedef struct packed {
    logic       open;   // emit an opening quote first
    kind_t      kind;
    logic [7:0] ch;
  } desc_t;

endpackage

// ===== hdl/jse_if.sv =====
// handshake channel interfaces of the json string escaper

interface jse_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_close;

  modport source (output valid, output out_byte, output run_last, output string_close,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_close,
                output ready);
endinterface

// ===== hdl/jse_front.sv =====
// front end: takes input transfers, tracks the open string and classifies bytes
module jse_front (
  input  logic          clk,
  input  logic          rst_n,
  jse_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output jse_pkg::desc_t push_desc
);
  import jse_pkg::*;

  logic inside_r;
  logic inside_nxt;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_desc.open = !inside_r;
    push_desc.kind = KIND_PLAIN;
    push_desc.ch   = in_ch.data_byte;
    if (in_ch.cmd == CMD_END) begin
      push_desc.kind = KIND_CLOSE;
    end else begin
      case (in_ch.data_byte)
        CH_QUOTE: begin
          push_desc.kind = KIND_ESC;
          push_desc.ch   = CH_QUOTE;
        end
        CH_BSL: begin
          push_desc.kind = KIND_ESC;
          push_desc.ch   = CH_BSL;
        end
        CH_LF: begin
          push_desc.kind = KIND_ESC;
          push_desc.ch   = CH_N;
        end
        CH_CR: begin
          push_desc.kind = KIND_ESC;
          push_desc.ch   = CH_R;
        end
        CH_TAB: begin
          push_desc.kind = KIND_ESC;
          push_desc.ch   = CH_T;
        end
        default: begin
          if (in_ch.data_byte < CTRL_LIMIT) begin
            push_desc.kind = KIND_UNI;
          end
        end
      endcase
    end
  end

  assign inside_nxt = push ? (in_ch.cmd == CMD_BYTE) : inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

endmodule

// ===== hdl/jse_queue.sv =====
// short descriptor queue between front and back
module jse_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jse_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output jse_pkg::desc_t head_desc
);
  import jse_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== hdl/jse_back.sv =====
// back end: emits each descriptor's bytes, one per cycle while out_ch is ready
module jse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  jse_pkg::desc_t head_desc,
  output logic           pop,
  jse_out_if.source      out_ch
);
  import jse_pkg::*;

  step_t      step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  logic       close_r;

  logic       load;
  step_t      body_len;
  step_t      total;
  step_t      j;
  logic       is_last;
  logic [7:0] cur_byte;
  logic       cur_close;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = {4'h3, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

  assign load = head_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    case (head_desc.kind)
      KIND_ESC: body_len = step_t'(2);
      KIND_UNI: body_len = step_t'(6);
      default:  body_len = step_t'(1);
    endcase
    total   = body_len + step_t'(head_desc.open);
    is_last = (step_r == total - step_t'(1));
    j       = step_r - step_t'(head_desc.open);

    cur_close = 1'b0;
    if (head_desc.open && step_r == '0) begin
      cur_byte = CH_QUOTE;
    end else begin
      case (head_desc.kind)
        KIND_ESC: begin
          cur_byte = (j == '0) ? CH_BSL : head_desc.ch;
        end
        KIND_UNI: begin
          case (j)
            step_t'(0): cur_byte = CH_BSL;
            step_t'(1): cur_byte = CH_U;
            step_t'(4): cur_byte = hex_digit(head_desc.ch[7:4]);
            step_t'(5): cur_byte = hex_digit(head_desc.ch[3:0]);
            default:    cur_byte = CH_ZERO;
          endcase
        end
        KIND_CLOSE: begin
          cur_byte  = CH_QUOTE;
          cur_close = 1'b1;
        end
        default: begin
          cur_byte = head_desc.ch;
        end
      endcase
    end

    pop           = load && is_last;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = is_last ? '0 : step_r + step_t'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      run_last_r <= is_last;
      close_r    <= cur_close;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.run_last     = run_last_r;
  assign out_ch.string_close = close_r;

  // the step count never runs past the longest run
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < step_t'(MAX_RUN))
    else $error("back end step count out of range");

  // a run in progress keeps its descriptor at the queue head
  a_mid_run_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> head_valid)
    else $error("descriptor vanished in the middle of a run");

  // the closing quote always ends the run of its item
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && close_r) |-> run_last_r)
    else $error("closing quote not marked as last of run");

  // a descriptor leaves the queue only on the last byte of its run
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (step_r == '0) && run_last_r)
    else $error("descriptor popped before its run ended");

endmodule

// ===== hdl/json_string_escaper.sv =====
// top level of the json string escaper
// Turns a stream of raw bytes into quoted JSON string literals. Each input
// transfer carries either a string byte (cmd 0) or an end of string (cmd 1);
// each output transfer carries one byte of escaped text, with run_last on the
// last byte an input item causes and string_close on a closing quote. The
// first byte of a string gets an opening quote in front; an end of string with
// no string open gives an empty pair of quotes. Rate: plain text inside a
// string streams at one byte per cycle while the consumer is ready; the
// back-end sequencer emits one output byte per cycle while the consumer is
// ready. An item has one output byte for a plain byte or a closing quote, two
// for a short escape, six for a unicode escape, plus one for an opening quote
// (at most seven). The front end keeps taking items into a small descriptor
// queue (QUEUE_DEPTH entries) while the back end works, and the output
// register decouples the consumer. An input item passes through the descriptor
// queue and then the output register before its first output byte appears.
module json_string_escaper #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  jse_in_if.sink    in_ch,
  jse_out_if.source out_ch
);
  import jse_pkg::*;

  // front to queue
  logic  push;
  desc_t push_desc;
  logic  q_full;

  // queue to back
  logic  pop;
  logic  head_valid;
  desc_t head_desc;

  // classification and open-string tracking; ready only depends on queue fill
  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  // descriptor queue, lets the front run ahead while escapes are expanded
  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // expansion sequencer and output register
  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
